### src/md4hs_pkg.sv
// Shared types, constants and step functions for the MD4 stream hasher.
// Used by md4hs_front, md4hs_back and md4_hash_stream_core; no dependencies.
`default_nettype none
package md4hs_pkg;

    localparam int QueueDepth = 4;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] K_RND2 = 32'h5a827999;
    localparam logic [31:0] K_RND3 = 32'h6ed9eba1;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       eom;
    } t_item;

    typedef logic [31:0] t_word;

    function automatic logic [3:0] msg_index(input logic [5:0] step);
        logic [3:0] j;
        j = step[3:0];
        case (step[5:4])
            2'd0:    msg_index = j;
            2'd1:    msg_index = {j[1:0], j[3:2]};
            default: msg_index = {j[0], j[1], j[2], j[3]};
        endcase
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] step);
        logic [4:0] r;
        r = 5'd3;
        case (step[5:4])
            2'd0: begin
                case (step[1:0])
                    2'd0:    r = 5'd3;
                    2'd1:    r = 5'd7;
                    2'd2:    r = 5'd11;
                    default: r = 5'd19;
                endcase
            end
            2'd1: begin
                case (step[1:0])
                    2'd0:    r = 5'd3;
                    2'd1:    r = 5'd5;
                    2'd2:    r = 5'd9;
                    default: r = 5'd13;
                endcase
            end
            default: begin
                case (step[1:0])
                    2'd0:    r = 5'd3;
                    2'd1:    r = 5'd9;
                    2'd2:    r = 5'd11;
                    default: r = 5'd15;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic t_word round_fn(input logic [1:0] rnd, input t_word x,
                                       input t_word y, input t_word z);
        case (rnd)
            2'd0:    round_fn = (x & y) | (~x & z);
            2'd1:    round_fn = ((x & y) | (x & z) | (y & z)) + K_RND2;
            default: round_fn = (x ^ y ^ z) + K_RND3;
        endcase
    endfunction

    function automatic t_word rotl32(input t_word v, input logic [4:0] n);
        logic [63:0] d;
        d = {v, v} << n;
        return d[63:32];
    endfunction

endpackage
`default_nettype wire

### src/md4hs_front.sv
// Input side of the MD4 stream hasher: accepts items, drops empty ones and
// queues the rest for the compression engine. Depends on md4hs_pkg.
`default_nettype none
module md4hs_front #(
    parameter int DEPTH = md4hs_pkg::QueueDepth
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_byte_valid,
    input  wire logic           i_end_of_message,
    output logic                o_q_valid,
    output md4hs_pkg::t_item    o_q_item,
    input  wire logic           i_q_pop
);
    import md4hs_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    t_item           r_queue [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            do_write;
    logic            do_read;

    assign full      = (r_count == CntFull);
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_queue[r_rd_ptr];

    assign do_write = push && !full && (i_byte_valid || i_end_of_message);
    assign do_read  = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_write) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_read) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_write, do_read})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_queue[r_wr_ptr] <= '{data: i_data_byte, has_byte: i_byte_valid,
                                   eom: i_end_of_message};
        end
    end

endmodule
`default_nettype wire

### src/md4hs_back.sv
// Compression engine of the MD4 stream hasher: gathers bytes into the block,
// runs the 48 steps one per cycle, pads, and hands out the digest words.
// Depends on md4hs_pkg.
`default_nettype none
module md4hs_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire md4hs_pkg::t_item i_q_item,
    output logic                o_q_pop,
    output logic                empty,
    input  wire logic           pop,
    output logic [31:0]         o_digest_word,
    output logic [1:0]          o_word_index,
    output logic                o_last_word
);
    import md4hs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COMP = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_PAD  = 3'd3;
    localparam logic [2:0] S_LEN  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    localparam logic [5:0] LastStep = 6'd47;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_after, n_after;
    logic [5:0]  r_step, n_step;
    logic [5:0]  r_pos, n_pos;
    logic [60:0] r_total, n_total;
    logic        r_spill, n_spill;
    logic [1:0]  r_oidx, n_oidx;
    t_word       r_chain [4];
    t_word       n_chain [4];
    t_word       r_s [4];
    t_word       n_s [4];
    t_word       r_block [16];
    t_word       n_block [16];
    logic        r_ovalid, n_ovalid;
    t_word       r_oword, n_oword;
    logic [1:0]  r_oindex, n_oindex;
    logic        r_olast, n_olast;

    t_word       step_w;
    t_word       step_new;
    logic        out_free;
    logic [3:0]  pad_word;

    assign empty         = !r_ovalid;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oindex;
    assign o_last_word   = r_olast;
    assign out_free      = !r_ovalid || pop;
    assign pad_word      = r_pos[5:2];

    assign step_w   = r_block[msg_index(r_step)];
    assign step_new = rotl32(r_s[0] + round_fn(r_step[5:4], r_s[1], r_s[2], r_s[3])
                             + step_w, rot_amount(r_step));

    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_step   = r_step;
        n_pos    = r_pos;
        n_total  = r_total;
        n_spill  = r_spill;
        n_oidx   = r_oidx;
        n_chain  = r_chain;
        n_s      = r_s;
        n_block  = r_block;
        n_ovalid = r_ovalid && !pop;
        n_oword  = r_oword;
        n_oindex = r_oindex;
        n_olast  = r_olast;
        o_q_pop  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.has_byte) begin
                        for (int b = 0; b < 4; b++) begin
                            if (r_pos[1:0] == 2'(b)) begin
                                n_block[r_pos[5:2]][8*b +: 8] = i_q_item.data;
                            end
                        end
                        n_pos   = r_pos + 1'b1;
                        n_total = r_total + 1'b1;
                    end
                    if (i_q_item.has_byte && (r_pos == 6'd63)) begin
                        n_s     = r_chain;
                        n_step  = '0;
                        n_state = S_COMP;
                        n_after = i_q_item.eom ? S_PAD : S_IDLE;
                    end else if (i_q_item.eom) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_COMP: begin
                n_s[0] = r_s[3];
                n_s[1] = step_new;
                n_s[2] = r_s[1];
                n_s[3] = r_s[2];
                n_step = r_step + 1'b1;
                if (r_step == LastStep) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                for (int k = 0; k < 4; k++) begin
                    n_chain[k] = r_chain[k] + r_s[k];
                end
                n_state = r_after;
            end
            S_PAD: begin
                for (int k = 0; k < 16; k++) begin
                    if (4'(k) > pad_word) begin
                        n_block[k] = '0;
                    end else if (4'(k) == pad_word) begin
                        for (int b = 0; b < 4; b++) begin
                            if (2'(b) == r_pos[1:0]) begin
                                n_block[k][8*b +: 8] = PAD_BYTE;
                            end else if (2'(b) > r_pos[1:0]) begin
                                n_block[k][8*b +: 8] = '0;
                            end
                        end
                    end
                end
                if (r_pos[5:3] == 3'd7) begin
                    n_spill = 1'b1;
                    n_s     = r_chain;
                    n_step  = '0;
                    n_state = S_COMP;
                    n_after = S_LEN;
                end else begin
                    n_spill = 1'b0;
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (r_spill) begin
                    for (int k = 0; k < 14; k++) begin
                        n_block[k] = '0;
                    end
                end
                n_block[14] = {r_total[28:0], 3'b000};
                n_block[15] = r_total[60:29];
                n_s     = r_chain;
                n_step  = '0;
                n_state = S_COMP;
                n_after = S_EMIT;
                n_oidx  = '0;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oword  = r_chain[r_oidx];
                    n_oindex = r_oidx;
                    n_olast  = (r_oidx == 2'd3);
                    n_oidx   = r_oidx + 1'b1;
                    if (r_oidx == 2'd3) begin
                        n_chain[0] = IV_A;
                        n_chain[1] = IV_B;
                        n_chain[2] = IV_C;
                        n_chain[3] = IV_D;
                        n_pos      = '0;
                        n_total    = '0;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_after    <= S_IDLE;
            r_pos      <= '0;
            r_total    <= '0;
            r_spill    <= 1'b0;
            r_oidx     <= '0;
            r_ovalid   <= 1'b0;
            r_chain[0] <= IV_A;
            r_chain[1] <= IV_B;
            r_chain[2] <= IV_C;
            r_chain[3] <= IV_D;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_pos    <= n_pos;
            r_total  <= n_total;
            r_spill  <= n_spill;
            r_oidx   <= n_oidx;
            r_ovalid <= n_ovalid;
            r_chain  <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_s      <= n_s;
        r_block  <= n_block;
        r_oword  <= n_oword;
        r_oindex <= n_oindex;
        r_olast  <= n_olast;
    end

endmodule
`default_nettype wire

### src/md4_hash_stream_core.sv
// Top level of the MD4 stream hasher: input queue front end and compression
// back end. Depends on md4hs_pkg, md4hs_front and md4hs_back.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+-------------------------------------------
//  input   | push / full        | i_data_byte, i_byte_valid, i_end_of_message
//  result  | empty / pop        | o_digest_word, o_word_index, o_last_word
//
// The engine takes a queued byte per cycle while idle; each 64th byte starts
// the 48 compression steps, one per cycle, and the fold into the chaining
// words. End of message pads and hashes one more block, or two if the tail
// holds 56 or more bytes, then one digest word per cycle while pop keeps up.
// Items with neither a byte nor an end mark are taken and dropped at once.
// Reset is synchronous; no clearing pass is needed. The input queue lets
// push proceed while the engine compresses or waits on a full result slot.
`default_nettype none
module md4_hash_stream_core #(
    parameter int QUEUE_DEPTH = md4hs_pkg::QueueDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_end_of_message,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_digest_word,
    output logic [1:0]       o_word_index,
    output logic             o_last_word
);
    import md4hs_pkg::*;

    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    md4hs_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_byte_valid    (i_byte_valid),
        .i_end_of_message(i_end_of_message),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    md4hs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_digest_word(o_digest_word),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word)
    );

endmodule
`default_nettype wire
